/* rtl/blsp_pkg.sv */
// ---------------------------------------------------------------------------
// blsp_pkg
// Types, constants and helper functions shared by the backlight level stepper.
// ---------------------------------------------------------------------------
`default_nettype none

package blsp_pkg;

  localparam int PCT_W       = 16;
  localparam int DUTY_W      = 16;
  localparam int LEVEL_W     = 7;
  localparam int LEVEL_SLOTS = 32;
  localparam int IDX_W       = 5;
  // Dividend width covers 200 * 65535 + 65535; divisor width covers 2 * 65535.
  localparam int NUM_W       = 24;
  localparam int DEN_W       = 17;

  localparam logic [LEVEL_W-1:0] PCT_FULL = 7'd100;
  localparam logic [DEN_W-1:0]   DEN_DUTY = 17'd200;

  typedef enum logic [1:0] {
    OP_UP    = 2'd0,
    OP_DOWN  = 2'd1,
    OP_SET   = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef logic [LEVEL_W-1:0] level_table_t [LEVEL_SLOTS];

  localparam level_table_t LEVEL_TABLE = '{
    7'd1,   7'd2,   7'd4,   7'd6,   7'd9,   7'd12,  7'd16,  7'd20,
    7'd25,  7'd30,  7'd36,  7'd43,  7'd51,  7'd60,  7'd70,  7'd80,
    7'd90,  7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100,
    7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100
  };

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              start;
    logic              up;
    logic [PCT_W-1:0]  cur;
  } scan_req_t;

  // 200 * d built from three shifted copies.
  function automatic logic [NUM_W-1:0] times200(input logic [DUTY_W-1:0] d);
    logic [NUM_W-1:0] w;
    w = NUM_W'(d);
    return (w << 7) + (w << 6) + (w << 3);
  endfunction

  // Dividend for the duty division by 200. A zero level can only fall to the
  // lower clamp, which is round(max / 200) = floor((max + 100) / 200).
  function automatic logic [NUM_W-1:0] duty_numerator(input logic [LEVEL_W-1:0] level,
                                                       input logic [DUTY_W-1:0]  mx);
    logic [LEVEL_W:0] lv2;
    logic [NUM_W-1:0] p;
    lv2 = {level, 1'b0};
    p   = NUM_W'(lv2) * NUM_W'(mx);
    if (level == '0) begin
      return NUM_W'(mx) + NUM_W'(100);
    end else begin
      return p + NUM_W'(100);
    end
  endfunction

  function automatic logic [PCT_W-1:0] sat_pct(input logic [NUM_W-1:0] q);
    if (q[NUM_W-1:PCT_W] != '0) begin
      return '1;
    end else begin
      return q[PCT_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/blsp_if.sv */
// ---------------------------------------------------------------------------
// blsp_if
// Request and result channels of the backlight level stepper.
// ---------------------------------------------------------------------------
`default_nettype none

interface blsp_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [9:0] percent_request;

  modport source (output valid, output op, output percent_request, input ready);
  modport sink   (input valid, input op, input percent_request, output ready);
endinterface

interface blsp_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] percent_before;
  logic [15:0] percent_after;
  logic [15:0] duty_value;
  logic        duty_written;

  modport source (output valid, output percent_before, output percent_after,
                  output duty_value, output duty_written, input ready);
  modport sink   (input valid, input percent_before, input percent_after,
                  input duty_value, input duty_written, output ready);
endinterface

`default_nettype wire

/* rtl/blsp_divider.sv */
// ---------------------------------------------------------------------------
// blsp_divider
// Restoring divider that produces one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module blsp_divider
  import blsp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire div_req_t         req,
  output logic                  done,
  output logic [NUM_W-1:0]      quot
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] shreg;

  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] diff;
  logic             qbit;
  logic [DEN_W-1:0] rem_next;

  // The dividend leaves at the top of the shift register while quotient bits
  // enter at the bottom.
  always_comb begin
    shifted  = {rem, shreg[NUM_W-1]};
    diff     = {1'b0, shifted} - {2'b00, den};
    qbit     = ~diff[DEN_W+1];
    rem_next = qbit ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !req.start && busy && (cnt == CNT_W'(NUM_W - 1));
      if (req.start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        rem   <= '0;
        shreg <= req.num;
        den   <= req.den;
      end else if (busy) begin
        rem   <= rem_next;
        shreg <= {shreg[NUM_W-2:0], qbit};
        cnt   <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quot = shreg;

endmodule

`default_nettype wire

/* rtl/blsp_level_scan.sv */
// ---------------------------------------------------------------------------
// blsp_level_scan
// Walks the level table one entry per cycle to find the next or previous level.
// ---------------------------------------------------------------------------
`default_nettype none

module blsp_level_scan
  import blsp_pkg::*;
#(
  parameter int LEVEL_COUNT = 18
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire scan_req_t     req,
  output logic               done,
  output logic [LEVEL_W-1:0] level
);

  localparam logic [IDX_W-1:0] LAST = IDX_W'(LEVEL_COUNT - 1);

  logic             busy;
  logic             up;
  logic [IDX_W-1:0] idx;
  logic [PCT_W-1:0] cur;

  logic [LEVEL_W-1:0] entry;
  logic               hit;

  // Upwards the first entry above the percent wins; downwards the last one
  // below it. The end of the table stops the walk either way.
  always_comb begin
    entry = LEVEL_TABLE[idx];
    if (up) begin
      hit = (idx == LAST) || (cur < PCT_W'(entry));
    end else begin
      hit = (idx == '0) || (PCT_W'(entry) < cur);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !req.start && busy && hit;
      if (req.start) begin
        busy <= 1'b1;
        up   <= req.up;
        cur  <= req.cur;
        idx  <= req.up ? '0 : LAST;
      end else if (busy) begin
        if (hit) begin
          busy  <= 1'b0;
          level <= entry;
        end else if (up) begin
          idx <= idx + 1'b1;
        end else begin
          idx <= idx - 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/backlight_level_stepper.sv */
// ---------------------------------------------------------------------------
// backlight_level_stepper
// Holds a PWM backlight duty and steps it along a perceptual level table.
//
// The request channel carries an op (step up, step down, set percent, query)
// and a percent; every request gives exactly one item on the result channel
// with the percent before and after, the duty now driven and a written flag.
// The period maximum is written via cfg_write_en / cfg_write_data while the
// block is idle (a user rule, not enforced); a zero maximum counts as one.
//
// One request is worked on at a time. All divisions go through one serial
// divider at one quotient bit per cycle; a registered start launches it and
// a registered done flag hands back the quotient. A query uses it once; a set
// percent uses it three times; a step uses it three times as well and adds a
// walk along the level table.
//
// Reset clears the duty to zero and sets the period maximum to 65535. A
// finished result waits in an output register; the next request is taken
// meanwhile, and only its own result waits until the receiver is ready.
// ---------------------------------------------------------------------------
`default_nettype none

module backlight_level_stepper
  import blsp_pkg::*;
#(
  parameter int DUTY_BITS   = 16,
  parameter int LEVEL_COUNT = 18
) (
  input  wire logic        clk,
  input  wire logic        rst,
  blsp_req_if.sink         request,
  blsp_res_if.source       result,
  input  wire logic        cfg_write_en,
  input  wire logic [15:0] cfg_write_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BEFORE,
    S_SCAN,
    S_DUTY,
    S_AFTER,
    S_DONE
  } state_t;

  state_t state;

  logic [DUTY_W-1:0]    duty_period_max;
  logic [DUTY_BITS-1:0] duty;
  op_t                  op;
  logic [9:0]           percent_req;
  logic [PCT_W-1:0]     pct_before;
  logic [PCT_W-1:0]     after;
  logic                 written;

  div_req_t             div_req;
  scan_req_t            scan_req;
  logic                 div_done;
  logic [NUM_W-1:0]     quot;
  logic                 scan_done;
  logic [LEVEL_W-1:0]   scan_level;

  logic [DUTY_W-1:0]    mx;
  logic [DUTY_W-1:0]    duty16;
  logic [DUTY_W-1:0]    new_duty16;
  logic [LEVEL_W-1:0]   set_level;
  logic                 accept;
  logic                 res_free;
  logic                 div_start_next;
  logic                 scan_start_next;

  always_comb begin
    mx         = (duty_period_max == '0) ? DUTY_W'(1) : duty_period_max;
    duty16     = DUTY_W'(duty);
    // The stored duty keeps only DUTY_BITS bits of the new value.
    new_duty16 = DUTY_W'(DUTY_BITS'(quot[DUTY_W-1:0]));
    set_level  = (percent_req > 10'(PCT_FULL)) ? PCT_FULL : percent_req[LEVEL_W-1:0];
    accept     = request.valid && request.ready;
    res_free   = !result.valid || result.ready;
    div_start_next  = (state == S_IDLE && accept) ||
                      (state == S_BEFORE && div_done && op == OP_SET) ||
                      (state == S_SCAN && scan_done) ||
                      (state == S_DUTY && div_done);
    scan_start_next = (state == S_BEFORE) && div_done &&
                      (op == OP_UP || op == OP_DOWN);
  end

  assign request.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_period_max <= 16'hFFFF;
    end else if (cfg_write_en) begin
      duty_period_max <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      duty           <= '0;
      div_req.start  <= 1'b0;
      scan_req.start <= 1'b0;
      result.valid   <= 1'b0;
    end else begin
      div_req.start  <= div_start_next;
      scan_req.start <= scan_start_next;
      if (result.valid && result.ready && state != S_DONE) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op            <= op_t'(request.op);
            percent_req   <= request.percent_request;
            div_req.num   <= times200(duty16) + NUM_W'(mx);
            div_req.den   <= {mx, 1'b0};
            state         <= S_BEFORE;
          end
        end
        S_BEFORE: begin
          if (div_done) begin
            pct_before <= sat_pct(quot);
            if (op == OP_QUERY) begin
              after   <= sat_pct(quot);
              written <= 1'b0;
              state   <= S_DONE;
            end else if (op == OP_SET) begin
              div_req.num   <= duty_numerator(set_level, mx);
              div_req.den   <= DEN_DUTY;
              state         <= S_DUTY;
            end else begin
              scan_req.up    <= (op == OP_UP);
              scan_req.cur   <= sat_pct(quot);
              state          <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            div_req.num   <= duty_numerator(scan_level, mx);
            div_req.den   <= DEN_DUTY;
            state         <= S_DUTY;
          end
        end
        S_DUTY: begin
          if (div_done) begin
            duty          <= DUTY_BITS'(quot[DUTY_W-1:0]);
            written       <= 1'b1;
            div_req.num   <= times200(new_duty16) + NUM_W'(mx);
            div_req.den   <= {mx, 1'b0};
            state         <= S_AFTER;
          end
        end
        S_AFTER: begin
          if (div_done) begin
            after <= sat_pct(quot);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_free) begin
            result.valid          <= 1'b1;
            result.percent_before <= pct_before;
            result.percent_after  <= after;
            result.duty_value     <= duty16;
            result.duty_written   <= written;
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  blsp_divider u_divider (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (quot)
  );

  blsp_level_scan #(
    .LEVEL_COUNT (LEVEL_COUNT)
  ) u_level_scan (
    .clk   (clk),
    .rst   (rst),
    .req   (scan_req),
    .done  (scan_done),
    .level (scan_level)
  );

endmodule

`default_nettype wire
